/* design/lpmc_pkg.sv */
// Package with shared constants for the LiDAR point motion compensation block.
`timescale 1ns / 1ps
package lpmc_pkg;

   localparam int ATAN_LEN = 24;

   // atan(2^-i) with 2^32 counts per turn.
   localparam logic [31:0] ATAN_TURN [0:ATAN_LEN-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   localparam int CSR_IDX_BITS = 3;
   localparam int VEL_BITS     = 16;
   localparam int PERIOD_BITS  = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_END_X  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_END_Y  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VEL_X  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VEL_Y  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VEL_Z  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD = 3'd5;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd6554;
   localparam logic [31:0]            HALF_TURN    = 32'h8000_0000;

endpackage

/* design/lidar_point_motion_compensate.sv */
// Top level of the LiDAR point motion compensation pipeline.
`timescale 1ns / 1ps
// Usage
// Points arrive on the req_ stream: tdata carries x, y and z from the lowest bit up, and
// tlast marks the final point of a scan. Each transfer yields exactly one transfer on the
// rsp_ stream with the compensated coordinates, the end-of-scan mark on tlast and a
// saturation flag on tuser.
// The csr_ channel writes the end point (which fixes the reference azimuth), the three
// velocity components and the scan period. It is always ready, and should only be written
// while no point is in flight.
// From input transfer to output valid a point passes one entry stage, one CORDIC
// iteration per stage, azimuth rounding, the time product, the velocity product and the
// final subtract and clamp, which doubles as the output register.
// Throughput is one point per clock. The azimuth of the point and of the end point run
// side by side in the CORDIC stages, so a new end point takes effect on the next point.
// When the receiver stalls with a result waiting, the whole pipeline holds and req_tready
// falls; empty stages simply travel along with the data while the output is free.
// Reset clears every valid bit and returns the registers to their defaults: zero end point,
// zero velocity and a scan period of 6554 (ten revolutions per second).
// A point marked last passes unchanged with the saturation flag clear.
module lidar_point_motion_compensate
   import lpmc_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int COORD_BITS   = 18
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x, point_y, point_z, zero padding
   input  logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z, zero padding
   output logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   // saturated
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_IDX_BITS-1:0]           csr_index,
   input  logic [((COORD_BITS > 16) ? COORD_BITS : 16)-1:0] csr_data
);

   localparam int CB     = COORD_BITS;
   localparam int DATA_W = ((3*CB+7)/8)*8;
   localparam int PAY_W  = 3*CB + 1;
   localparam int CW     = CB + 3;                 // CORDIC datapath width
   localparam int N      = CORDIC_STEPS;
   localparam int DEPTH  = N + 5;
   localparam int S_M2   = N + 3;
   localparam int S_OUT  = N + 4;
   localparam int RW     = ((CB > 17) ? CB : 17) + 2;
   localparam int PW     = 32 + 1 + VEL_BITS;      // velocity product width

   // Configuration registers.
   logic signed [CB-1:0]          end_x_ff, end_y_ff;
   logic signed [VEL_BITS-1:0]    vel_ff [0:2];
   logic        [PERIOD_BITS-1:0] period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_x_ff  <= '0;
         end_y_ff  <= '0;
         vel_ff[0] <= '0;
         vel_ff[1] <= '0;
         vel_ff[2] <= '0;
         period_ff <= PERIOD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_END_X:  end_x_ff  <= csr_data[CB-1:0];
            CSR_END_Y:  end_y_ff  <= csr_data[CB-1:0];
            CSR_VEL_X:  vel_ff[0] <= csr_data[VEL_BITS-1:0];
            CSR_VEL_Y:  vel_ff[1] <= csr_data[VEL_BITS-1:0];
            CSR_VEL_Z:  vel_ff[2] <= csr_data[VEL_BITS-1:0];
            CSR_PERIOD: period_ff <= csr_data[PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline advance: every stage moves together unless a result is held at the output.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic             valid_ff [0:DEPTH-1];
   logic [PAY_W-1:0] pay_ff   [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_tvalid;
         for (int s = 1; s < DEPTH; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pay_ff[0] <= {req_tlast, req_tdata[3*CB-1:0]};
         for (int s = 1; s < DEPTH; s++) pay_ff[s] <= pay_ff[s-1];
      end
   end

   // CORDIC state: lane 0 is the point, lane 1 the end point.
   logic signed [CW-1:0] cx_ff [0:N][0:1];
   logic signed [CW-1:0] cy_ff [0:N][0:1];
   logic        [31:0]   z_ff  [0:N][0:1];
   logic                 zero_ff [0:N][0:1];

   logic signed [CW-1:0] lane_x [0:1];
   logic signed [CW-1:0] lane_y [0:1];

   always_comb begin
      lane_x[0] = CW'(-$signed(req_tdata[2*CB-1:CB]));
      lane_y[0] = CW'($signed(req_tdata[CB-1:0]));
      lane_x[1] = CW'(-end_y_ff);
      lane_y[1] = CW'(end_x_ff);
   end

   genvar g, l;
   generate
      for (l = 0; l < 2; l++) begin : g_entry
         always_ff @(posedge clock) begin
            if (advance) begin
               zero_ff[0][l] <= (lane_x[l] == '0) && (lane_y[l] == '0);
               if (lane_x[l] < 0) begin
                  cx_ff[0][l] <= -lane_x[l];
                  cy_ff[0][l] <= -lane_y[l];
                  z_ff[0][l]  <= HALF_TURN;
               end else begin
                  cx_ff[0][l] <= lane_x[l];
                  cy_ff[0][l] <= lane_y[l];
                  z_ff[0][l]  <= '0;
               end
            end
         end
      end

      for (g = 0; g < N; g++) begin : g_step
         for (l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge clock) begin
               if (advance) begin
                  zero_ff[g+1][l] <= zero_ff[g][l];
                  if (cy_ff[g][l] >= 0) begin
                     cx_ff[g+1][l] <= cx_ff[g][l] + (cy_ff[g][l] >>> g);
                     cy_ff[g+1][l] <= cy_ff[g][l] - (cx_ff[g][l] >>> g);
                     z_ff[g+1][l]  <= z_ff[g][l] + ATAN_TURN[g];
                  end else begin
                     cx_ff[g+1][l] <= cx_ff[g][l] - (cy_ff[g][l] >>> g);
                     cy_ff[g+1][l] <= cy_ff[g][l] + (cx_ff[g][l] >>> g);
                     z_ff[g+1][l]  <= z_ff[g][l] - ATAN_TURN[g];
                  end
               end
            end
         end
      end
   endgenerate

   // Round both angles to 16 bits of a turn and take the wrapped difference.
   logic [15:0] theta_in [0:1];
   logic [15:0] delta_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         theta_in[k] = zero_ff[N][k] ? 16'd0 : (z_ff[N][k][31:16] + {15'd0, z_ff[N][k][15]});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) delta_ff <= theta_in[0] - theta_in[1];
   end

   // Elapsed time as a fraction of a turn times the scan period.
   logic [31:0] dt_ff;

   always_ff @(posedge clock) begin
      if (advance) dt_ff <= delta_ff * period_ff;
   end

   // Displacement products, one multiplier per axis.
   logic signed [PW-1:0] prod_ff [0:2];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) prod_ff[k] <= $signed({1'b0, dt_ff}) * vel_ff[k];
      end
   end

   // Round, subtract and clamp.
   localparam logic signed [RW-1:0] C_HI = RW'((64'sd1 <<< (CB-1)) - 64'sd1);
   localparam logic signed [RW-1:0] C_LO = -C_HI - RW'(1);

   logic signed [PW-1:0] round_sum [0:2];
   logic signed [RW-1:0] diff      [0:2];
   logic        [CB-1:0] res_in    [0:2];
   logic                 sat_in;
   logic [PAY_W-1:0]     in_pay;
   logic [CB-1:0]        res_ff    [0:2];
   logic                 sat_ff, last_ff;

   assign in_pay = pay_ff[S_M2];

   always_comb begin
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         round_sum[k] = prod_ff[k] + PW'(33'sh0_8000_0000);
         diff[k] = RW'($signed(in_pay[k*CB +: CB])) - RW'($signed(round_sum[k][PW-1:32]));
         if (diff[k] > C_HI) begin
            res_in[k] = C_HI[CB-1:0];
            sat_in    = 1'b1;
         end else if (diff[k] < C_LO) begin
            res_in[k] = C_LO[CB-1:0];
            sat_in    = 1'b1;
         end else begin
            res_in[k] = diff[k][CB-1:0];
         end
         if (in_pay[3*CB]) res_in[k] = in_pay[k*CB +: CB];
      end
      if (in_pay[3*CB]) sat_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) res_ff[k] <= res_in[k];
         sat_ff  <= sat_in;
         last_ff <= in_pay[3*CB];
      end
   end

   assign rsp_tvalid = valid_ff[S_OUT];
   assign rsp_tdata  = DATA_W'({res_ff[2], res_ff[1], res_ff[0]});
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = sat_ff;

   // Checks.
   a_last_unsaturated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser)
      else $error("last point reported as saturated");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         ($signed(res_ff[0]) == C_HI) || ($signed(res_ff[0]) == C_LO) ||
         ($signed(res_ff[1]) == C_HI) || ($signed(res_ff[1]) == C_LO) ||
         ($signed(res_ff[2]) == C_HI) || ($signed(res_ff[2]) == C_LO))
      else $error("saturation flag without a clamped coordinate");

   a_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(res_ff[0]) && $stable(sat_ff))
      else $error("stalled result changed");

   a_last_flag_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pay_ff[S_OUT][3*CB] == last_ff)
      else $error("last flag lost its payload alignment");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!valid_ff[S_OUT] || rsp_tready))
      else $error("input ready disagrees with output stall");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the LiDAR point motion compensation block.
`timescale 1ns / 1ps
module tb_top;
   import lpmc_pkg::*;

   localparam int STEPS      = 16;
   localparam int CB         = 18;
   localparam int TDATA_W    = ((3*CB+7)/8)*8;
   localparam int CSR_W      = (CB > 16) ? CB : 16;
   localparam int LATENCY    = STEPS + 5;
   localparam int CYCLE_CAP  = 2000000;
   localparam int RANDOM_PER_PHASE = 250;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct {
      logic [CB-1:0] x, y, z;
      logic          last, sat;
   } comp_point_type;

   // Holds the register file as the block should see it, works out the compensated
   // point for every accepted transfer and checks results strictly in order.
   class motion_scoreboard;
      logic signed [CB-1:0] end_x, end_y;
      logic signed [15:0]   vel_x, vel_y, vel_z;
      logic [15:0]          period;
      comp_point_type       awaited[$];
      int                   errors, checked;

      function void restore_defaults();
         end_x = '0; end_y = '0; vel_x = '0; vel_y = '0; vel_z = '0;
         period = PERIOD_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_END_X:  end_x = data[CB-1:0];
            CSR_END_Y:  end_y = data[CB-1:0];
            CSR_VEL_X:  vel_x = data[15:0];
            CSR_VEL_Y:  vel_y = data[15:0];
            CSR_VEL_Z:  vel_z = data[15:0];
            CSR_PERIOD: period = data[15:0];
            default: ;
         endcase
      endfunction

      // Azimuth atan2(px, -py) in 65536 counts per turn, by vectoring rotation.
      function logic [15:0] heading(longint px, longint py);
         longint cx, cy, nx;
         logic [31:0] ang;
         logic [32:0] rounded;
         if (px == 0 && py == 0) return 16'd0;
         cx = -py; cy = px; ang = '0;
         if (cx < 0) begin
            cx = -cx; cy = -cy; ang = HALF_TURN;
         end
         for (int i = 0; i < STEPS; i++) begin
            if (cy >= 0) begin
               nx = cx + (cy >>> i); cy = cy - (cx >>> i); ang = ang + ATAN_TURN[i];
            end else begin
               nx = cx - (cy >>> i); cy = cy + (cx >>> i); ang = ang - ATAN_TURN[i];
            end
            cx = nx;
         end
         rounded = {1'b0, ang} + 33'h8000;
         return rounded[31:16];
      endfunction

      function logic [CB-1:0] shift_back(longint c, longint dt, longint v, inout logic sat);
         longint d, r;
         d = (dt * v + 64'sh8000_0000) >>> 32;
         r = c - d;
         if (r > 131071) begin r = 131071; sat = 1'b1; end
         if (r < -131072) begin r = -131072; sat = 1'b1; end
         return r[CB-1:0];
      endfunction

      function void note_point(logic signed [CB-1:0] px, py, pz, logic last);
         comp_point_type e;
         logic [15:0] delta;
         longint dt;
         e.last = last; e.sat = 1'b0;
         if (last) begin
            e.x = px; e.y = py; e.z = pz;
         end else begin
            delta = heading(px, py) - heading(end_x, end_y);
            dt = longint'(delta) * longint'(period);
            e.x = shift_back(px, dt, vel_x, e.sat);
            e.y = shift_back(py, dt, vel_y, e.sat);
            e.z = shift_back(pz, dt, vel_z, e.sat);
         end
         awaited.push_back(e);
      endfunction

      function void check_result(logic [TDATA_W-1:0] data, logic last, logic sat);
         comp_point_type e;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                     data[CB-1:0], data[2*CB-1:CB], data[3*CB-1:2*CB]);
            errors++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (data[CB-1:0] !== e.x || data[2*CB-1:CB] !== e.y ||
             data[3*CB-1:2*CB] !== e.z || last !== e.last || sat !== e.sat) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h last=%b sat=%b", $time,
                     e.x, e.y, e.z, e.last, e.sat);
            $display("%0t:          actual   x=%h y=%h z=%h last=%b sat=%b", $time,
                     data[CB-1:0], data[2*CB-1:CB], data[3*CB-1:2*CB], last, sat);
            errors++;
         end
      endfunction
   endclass

   logic                    clock, reset;
   logic                    req_tvalid, req_tready, req_tlast;
   logic [TDATA_W-1:0]      req_tdata;
   logic                    rsp_tvalid, rsp_tready, rsp_tlast, rsp_tuser;
   logic [TDATA_W-1:0]      rsp_tdata;
   logic                    csr_valid, csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_W-1:0]        csr_data;

   motion_scoreboard sb = new();
   int  sender_idle_pct, receiver_stall_pct;
   int  hold_left, cycles, sent, last_sent, saturations;
   bit  hold_request;

   lidar_point_motion_compensate #(.CORDIC_STEPS(STEPS), .COORD_BITS(CB)) dut (.*);

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // The cycle counter guards against a hung pipeline.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver side: random stalls, or a long hold-off when one is requested, so that the
   // pipeline fills up and the block must drop req_tready.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Results are sampled at the rising edge, where the transfer happens.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         if (rsp_tuser) saturations++;
      end
   end

   task automatic send_point(logic [CB-1:0] px, py, pz, logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(TDATA_W-3*CB){1'b0}}, pz, py, px};
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_point(px, py, pz, last);
      sent++;
      if (last) last_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Waits until every expected result is in, then lets the pipeline run dry.
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic configure(logic [CSR_W-1:0] ex, ey, vx, vy, vz, per);
      write_csr(CSR_END_X, ex);
      write_csr(CSR_END_Y, ey);
      write_csr(CSR_VEL_X, vx);
      write_csr(CSR_VEL_Y, vy);
      write_csr(CSR_VEL_Z, vz);
      write_csr(CSR_PERIOD, per);
   endtask

   function automatic logic [CB-1:0] pick_coord();
      case ($urandom_range(9))
         0: return 18'h1FFFF;
         1: return 18'h20000;
         2: return '0;
         3: return CB'($urandom_range(511)) - CB'(256);
         default: return CB'($urandom);
      endcase
   endfunction

   initial begin
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      csr_valid = 1'b0; csr_index = CSR_END_X; csr_data = '0;
      sender_idle_pct = 0; receiver_stall_pct = 0;
      sent = 0; last_sent = 0;
      sb.restore_defaults();
      reset = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed part: first with the reset defaults, then with a modest motion.
      send_point(18'd1000, 18'd2000, 18'd3000, 1'b0);
      drain();
      configure(18'd100, -18'sd50, 18'd300, -18'sd700, 18'd1200, 18'd6554);
      send_point('0, '0, 18'd77, 1'b0);                      // point at the origin
      send_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 1'b0);
      send_point(18'h20000, 18'h20000, 18'h20000, 1'b0);
      send_point(18'h1FFFF, 18'h20000, 18'h1FFFF, 1'b0);
      send_point(18'h20000, 18'h1FFFF, 18'h20000, 1'b0);
      send_point(18'h1FFFF, 18'h20000, 18'h20000, 1'b1);     // last point passes as is
      send_point(18'd500, '0, '0, 1'b0);
      send_point(-18'sd500, '0, '0, 1'b0);
      send_point('0, 18'd500, '0, 1'b0);
      send_point('0, -18'sd500, '0, 1'b0);
      send_point(18'd100, -18'sd50, '0, 1'b0);               // on the reference azimuth
      send_point(18'd100, -18'sd51, '0, 1'b0);
      drain();
      // Origin as end point, spare register indexes that must be ignored, zero period.
      configure('0, '0, 18'h07FFF, 18'h08000, 18'h07FFF, 18'd0);
      write_csr(CSR_SPARE_6, 18'h3FFFF);
      write_csr(CSR_SPARE_7, 18'h15555);
      send_point(18'h1FFFF, 18'd5, 18'h20000, 1'b0);
      send_point(-18'sd3, 18'd9, 18'd2, 1'b0);
      drain();

      // Random phases, each with its own register setting and one of four idling patterns.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(18'h1FFFF, 18'h20000, 18'h07FFF, 18'h07FFF, 18'h07FFF, 18'hFFFF);
            1: configure(18'h20000, 18'h1FFFF, 18'h08000, 18'h08000, 18'h08000, 18'd1);
            2: configure(18'd12000, 18'd3000, 18'($urandom), 18'($urandom),
                         18'($urandom), 18'd6554);
            default: configure(18'($urandom), 18'($urandom), 18'($urandom),
                               18'($urandom), 18'($urandom), 18'($urandom));
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
            default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
         endcase
         if (phase == 4) hold_request = 1'b1;
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_point(pick_coord(), pick_coord(), pick_coord(), $urandom_range(19) == 0);
         drain();
      end

      $display("Sent %0d points (%0d marked last) over nine register settings;", sent,
               last_sent);
      $display("checked %0d results, %0d of them clamped.", sb.checked, saturations);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
